>>> design/clr_pkg.sv
// Package with shared constants and types for the clipped line rasterizer.
`timescale 1ns / 1ps
package clr_pkg;
  localparam int MaxDimDefault = 64;
  localparam int CoordW = 16;
  localparam int WideW = 36;
  localparam int ClipPasses = 32;

  localparam logic [3:0] OC_LEFT   = 4'b0001;
  localparam logic [3:0] OC_RIGHT  = 4'b0010;
  localparam logic [3:0] OC_TOP    = 4'b0100;
  localparam logic [3:0] OC_BOTTOM = 4'b1000;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    DP_NONE, DP_LOAD, DP_SWAP, DP_CLIP_MUL, DP_CLIP_DIV, DP_CLIP_FIN, DP_DRAW_INIT, DP_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] oc1;
    logic [3:0] oc2;
    logic       div_done;
    logic       draw_last;
  } dp_status_t;
endpackage

>>> design/clr_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module clr_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [clr_pkg::WideW-1:0] dividend,
  input  logic signed [clr_pkg::WideW-1:0] divisor,
  output logic                             done,
  output logic signed [clr_pkg::WideW-1:0] quotient
);
  import clr_pkg::*;
  localparam int CntW = $clog2(WideW + 1);

  logic [WideW-1:0] rem;
  logic [WideW-1:0] quo;
  logic [WideW-1:0] den;
  logic [CntW-1:0]  count;
  logic             busy;
  logic             neg;
  logic [WideW:0]   trial;
  logic [WideW-1:0] rem_shift;

  assign rem_shift = {rem[WideW-2:0], quo[WideW-1]};
  assign trial = {1'b0, rem_shift} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CntW'(WideW);
        neg <= dividend[WideW-1] ^ divisor[WideW-1];
        quo <= dividend[WideW-1] ? WideW'(-dividend) : WideW'(dividend);
        den <= divisor[WideW-1] ? WideW'(-divisor) : WideW'(divisor);
        rem <= '0;
      end else if (busy) begin
        if (!trial[WideW]) begin
          rem <= trial[WideW-1:0];
          quo <= {quo[WideW-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[WideW-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);
endmodule

>>> design/clr_datapath.sv
// Datapath: endpoint registers, outcodes, clip arithmetic and Bresenham stepper.
`timescale 1ns / 1ps
module clr_datapath #(
  parameter int MAX_DIM = clr_pkg::MaxDimDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  clr_pkg::dp_cmd_t                 cmd,
  output clr_pkg::dp_status_t              status,
  input  logic [6:0]                       canvas_width,
  input  logic [6:0]                       canvas_height,
  input  logic signed [clr_pkg::CoordW-1:0] x_start,
  input  logic signed [clr_pkg::CoordW-1:0] y_start,
  input  logic signed [clr_pkg::CoordW-1:0] x_end,
  input  logic signed [clr_pkg::CoordW-1:0] y_end,
  input  logic [7:0]                       glyph_in,
  output logic [5:0]                       cur_x,
  output logic [5:0]                       cur_y,
  output logic [7:0]                       glyph
);
  import clr_pkg::*;
  localparam int CW = 18;

  logic signed [WideW-1:0] x1, y1, x2, y2;
  logic signed [WideW-1:0] w, h;
  logic signed [WideW-1:0] prod;
  logic signed [WideW-1:0] num, den;
  logic signed [WideW-1:0] base_q;
  logic                    div_start, div_done;
  logic [3:0]              oc1, oc2;
  logic signed [CW-1:0]    delta, dpr, dpru, major, cnt;
  logic signed [CW-1:0]    xinc, yinc;
  logic                    xmajor;
  logic signed [CW-1:0]    dxa, dya;
  logic signed [CW-1:0]    mul_a, mul_b;

  assign w = (canvas_width > 7'(MAX_DIM)) ? WideW'(MAX_DIM) : WideW'(canvas_width);
  assign h = (canvas_height > 7'(MAX_DIM)) ? WideW'(MAX_DIM) : WideW'(canvas_height);

  function automatic logic [3:0] outcode(input logic signed [WideW-1:0] x,
                                         input logic signed [WideW-1:0] y,
                                         input logic signed [WideW-1:0] wd,
                                         input logic signed [WideW-1:0] ht);
    logic [3:0] b;
    b = '0;
    if (x < 0) b |= OC_LEFT;
    else if (x >= wd) b |= OC_RIGHT;
    if (y < 0) b |= OC_TOP;
    else if (y >= ht) b |= OC_BOTTOM;
    return b;
  endfunction

  assign oc1 = outcode(x1, y1, w, h);
  assign oc2 = outcode(x2, y2, w, h);

  clr_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod), .divisor(den),
    .done(div_done), .quotient(base_q)
  );

  assign div_start = (cmd.op == DP_CLIP_DIV);
  assign dxa = (x2 > x1) ? CW'(x2 - x1) : CW'(x1 - x2);
  assign dya = (y2 > y1) ? CW'(y2 - y1) : CW'(y1 - y2);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        x1 <= WideW'(x_start); y1 <= WideW'(y_start);
        x2 <= WideW'(x_end);   y2 <= WideW'(y_end);
        glyph <= glyph_in;
      end
      DP_SWAP: begin
        x1 <= x2; y1 <= y2; x2 <= x1; y2 <= y1;
      end
      DP_CLIP_MUL: begin
        // Pick the edge, form the interpolation numerator and divisor.
        if (oc1[0]) begin
          num <= x2;
          den <= x2 - x1;
        end else if (oc1[1]) begin
          num <= x2 - (w - 1);
          den <= x2 - x1;
        end else if (oc1[2]) begin
          num <= y2;
          den <= y2 - y1;
        end else begin
          num <= y2 - (h - 1);
          den <= y2 - y1;
        end
      end
      DP_CLIP_DIV: ;
      DP_CLIP_FIN: begin
        if (oc1[0]) begin
          y1 <= y2 - base_q; x1 <= '0;
        end else if (oc1[1]) begin
          y1 <= y2 - base_q; x1 <= w - 1;
        end else if (oc1[2]) begin
          x1 <= x2 - base_q; y1 <= '0;
        end else begin
          x1 <= x2 - base_q; y1 <= h - 1;
        end
      end
      DP_DRAW_INIT: begin
        xinc <= (x1 > x2) ? -CW'(1) : CW'(1);
        yinc <= (y1 > y2) ? -CW'(1) : CW'(1);
        xmajor <= dxa >= dya;
        major <= (dxa >= dya) ? dxa : dya;
        cnt <= '0;
        dpr <= ((dxa >= dya) ? dya : dxa) <<< 1;
        dpru <= (((dxa >= dya) ? dya : dxa) - ((dxa >= dya) ? dxa : dya)) <<< 1;
        delta <= (((dxa >= dya) ? dya : dxa) <<< 1) - ((dxa >= dya) ? dxa : dya);
      end
      DP_STEP: begin
        cnt <= cnt + 1'b1;
        if (delta > 0) begin
          x1 <= x1 + WideW'(xinc); y1 <= y1 + WideW'(yinc);
          delta <= delta + dpru;
        end else begin
          if (xmajor) x1 <= x1 + WideW'(xinc); else y1 <= y1 + WideW'(yinc);
          delta <= delta + dpr;
        end
      end
      default: ;
    endcase
  end

  // Both factors fit in 18 signed bits, so an 18 by 18 multiplier is enough.
  assign mul_a = num[CW-1:0];
  assign mul_b = (oc1[0] || oc1[1]) ? CW'(y2 - y1) : CW'(x2 - x1);

  // The product sits in its own register ahead of the divider.
  always_ff @(posedge clk) begin
    if (cmd.op == DP_CLIP_MUL)
      prod <= prod;
    else
      prod <= mul_a * mul_b;
  end

  assign status.oc1 = oc1;
  assign status.oc2 = oc2;
  assign status.div_done = div_done;
  assign status.draw_last = (cnt == major) || (cnt == CW'(63));
  assign cur_x = x1[5:0];
  assign cur_y = y1[5:0];
endmodule

>>> design/clr_ctrl.sv
// Controller state machine sequencing clip passes, drawing and output handshake.
`timescale 1ns / 1ps
module clr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_plotted,
  output logic                 out_last,
  output clr_pkg::dp_cmd_t     cmd,
  input  clr_pkg::dp_status_t  status
);
  import clr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TEST, S_MUL, S_PROD, S_DIV, S_WAIT, S_FIN, S_INIT, S_EMIT, S_REJ
  } state_t;

  state_t     state;
  logic [5:0] passes;
  logic       emit_last;

  always_comb begin
    cmd.op = DP_NONE;
    unique case (state)
      S_IDLE: if (in_valid) cmd.op = DP_LOAD;
      S_TEST: begin
        if ((status.oc1 & status.oc2) == 4'b0 && status.oc1 == 4'b0 && status.oc2 != 4'b0
            && passes != 6'(ClipPasses))
          cmd.op = DP_SWAP;
      end
      S_MUL:  cmd.op = DP_CLIP_MUL;
      S_DIV:  cmd.op = DP_CLIP_DIV;
      S_FIN:  cmd.op = DP_CLIP_FIN;
      S_INIT: cmd.op = DP_DRAW_INIT;
      S_EMIT: if (out_ready && !emit_last) cmd.op = DP_STEP;
      default: cmd.op = DP_NONE;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_EMIT) || (state == S_REJ);
  assign out_plotted = (state == S_EMIT);
  assign out_last = (state == S_REJ) || emit_last;
  assign emit_last = status.draw_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      passes <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          state <= S_TEST;
          passes <= '0;
        end
        S_TEST: begin
          if (passes == 6'(ClipPasses) || (status.oc1 & status.oc2) != 4'b0) state <= S_REJ;
          else if (status.oc1 == 4'b0 && status.oc2 == 4'b0) state <= S_INIT;
          else begin
            passes <= passes + 1'b1;
            if (status.oc1 != 4'b0) state <= S_MUL;
          end
        end
        S_MUL:  state <= S_PROD;
        S_PROD: state <= S_DIV;
        S_DIV:  state <= S_WAIT;
        S_WAIT: if (status.div_done) state <= S_FIN;
        S_FIN:  state <= S_TEST;
        S_INIT: state <= S_EMIT;
        S_EMIT: if (out_ready && emit_last) state <= S_IDLE;
        S_REJ:  if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while output pending");
  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    passes <= 6'(ClipPasses)) else $error("clip pass count overran");
  a_rej_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_REJ && out_ready) |=> state == S_IDLE) else $error("reject did not end");
endmodule

>>> design/clipped_line_rasterizer.sv
// Top level of the clipped line rasterizer.
`timescale 1ns / 1ps
// One line per transaction: each clip pass waits on the radix-2 divider, with at most
// 32 clip passes and swaps in all, then one pixel per cycle while out_ready is high,
// up to 64 pixels; the next line is accepted after the last pixel is taken.
module clipped_line_rasterizer #(
  parameter int MAX_DIM = clr_pkg::MaxDimDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [6:0]                         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [clr_pkg::CoordW-1:0]  x_start,
  input  logic signed [clr_pkg::CoordW-1:0]  y_start,
  input  logic signed [clr_pkg::CoordW-1:0]  x_end,
  input  logic signed [clr_pkg::CoordW-1:0]  y_end,
  input  logic [7:0]                         glyph_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [5:0]                         pixel_x,
  output logic [5:0]                         pixel_y,
  output logic [7:0]                         glyph_out,
  output logic                               plotted,
  output logic                               last
);
  import clr_pkg::*;

  logic [6:0]  canvas_width, canvas_height;
  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [5:0]  cx, cy;
  logic [7:0]  g;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width <= 7'd64;
      canvas_height <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) canvas_width <= cfg_data;
      else canvas_height <= cfg_data;
    end
  end

  clr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_plotted(plotted),
    .out_last(last), .cmd(cmd), .status(status)
  );

  clr_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .canvas_width(canvas_width), .canvas_height(canvas_height),
    .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
    .glyph_in(glyph_in), .cur_x(cx), .cur_y(cy), .glyph(g)
  );

  assign pixel_x = plotted ? cx : 6'd0;
  assign pixel_y = plotted ? cy : 6'd0;
  assign glyph_out = plotted ? g : 8'd0;
endmodule

>>> sim/testbench.sv
// Self-checking testbench for the clipped line rasterizer.
`timescale 1ns / 1ps
module testbench;
  import clr_pkg::*;

  typedef struct packed {
    logic signed [15:0] xs;
    logic signed [15:0] ys;
    logic signed [15:0] xe;
    logic signed [15:0] ye;
    logic [7:0]         glyph;
  } line_t;

  typedef struct packed {
    logic [5:0] px;
    logic [5:0] py;
    logic [7:0] glyph;
    logic       plotted;
    logic       last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_WIDTH;
  logic [6:0] cfg_data = 7'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] x_start = '0, y_start = '0, x_end = '0, y_end = '0;
  logic [7:0] glyph_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] pixel_x, pixel_y;
  logic [7:0] glyph_out;
  logic plotted, last;

  line_t  pending_lines[$];
  pixel_t expected_pixels[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_lines = 1'b0;
  int mismatches = 0;
  int pixels_seen = 0;
  int lines_sent = 0;
  int rejects_seen = 0;
  logic [6:0] width_reg = 7'd64;
  logic [6:0] height_reg = 7'd64;

  always #2 clk = ~clk;

  clipped_line_rasterizer dut (.*);

  function automatic logic [3:0] region_code(longint x, longint y, longint w, longint h);
    logic [3:0] code;
    code = 4'b0;
    if (x < 0) code |= OC_LEFT;
    else if (x >= w) code |= OC_RIGHT;
    if (y < 0) code |= OC_TOP;
    else if (y >= h) code |= OC_BOTTOM;
    return code;
  endfunction

  // Expected pixels of one line under the current canvas size.
  task automatic rasterize_line(input line_t ln);
    longint x1, y1, x2, y2, w, h, t;
    longint dx, dy, xinc, yinc, major, minor, dpr, dpru, delta;
    logic [3:0] c1, c2;
    bit xmajor;
    pixel_t p;
    w = (width_reg > 64) ? 64 : width_reg;
    h = (height_reg > 64) ? 64 : height_reg;
    x1 = ln.xs; y1 = ln.ys; x2 = ln.xe; y2 = ln.ye;
    for (int pass = 0; pass < ClipPasses; pass++) begin
      c1 = region_code(x1, y1, w, h);
      c2 = region_code(x2, y2, w, h);
      if ((c1 & c2) != 0) break;
      if (c1 == 0) begin
        if (c2 == 0) begin
          dx = (x2 > x1) ? x2 - x1 : x1 - x2;
          dy = (y2 > y1) ? y2 - y1 : y1 - y2;
          xinc = (x1 > x2) ? -1 : 1;
          yinc = (y1 > y2) ? -1 : 1;
          xmajor = dx >= dy;
          major = xmajor ? dx : dy;
          minor = xmajor ? dy : dx;
          dpr = minor * 2;
          dpru = dpr - major * 2;
          delta = dpr - major;
          for (longint i = 0; i <= major && i < 64; i++) begin
            p.px = x1[5:0]; p.py = y1[5:0]; p.glyph = ln.glyph;
            p.plotted = 1'b1; p.last = (i == major);
            expected_pixels.push_back(p);
            if (delta > 0) begin
              x1 += xinc; y1 += yinc; delta += dpru;
            end else begin
              if (xmajor) x1 += xinc; else y1 += yinc;
              delta += dpr;
            end
          end
          return;
        end
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
        continue;
      end
      // SystemVerilog division truncates toward zero, as required.
      if (c1 & OC_LEFT) begin
        y1 = y2 - (x2 * (y2 - y1)) / (x2 - x1); x1 = 0;
      end else if (c1 & OC_RIGHT) begin
        y1 = y2 - ((x2 - (w - 1)) * (y2 - y1)) / (x2 - x1); x1 = w - 1;
      end else if (c1 & OC_TOP) begin
        x1 = x2 - (y2 * (x2 - x1)) / (y2 - y1); y1 = 0;
      end else begin
        x1 = x2 - ((y2 - (h - 1)) * (x2 - x1)) / (y2 - y1); y1 = h - 1;
      end
    end
    p = '0; p.last = 1'b1;
    expected_pixels.push_back(p);
  endtask

  // Driver: presents queued lines and predicts their pixels on acceptance.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        rasterize_line({x_start, y_start, x_end, y_end, glyph_in});
        lines_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_lines.size() > 0 && !hold_lines &&
            $urandom_range(99) >= send_idle_pct) begin
          line_t ln;
          ln = pending_lines.pop_front();
          in_valid <= 1'b1;
          {x_start, y_start, x_end, y_end, glyph_in} <= ln;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compares each accepted pixel with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      pixel_t got, want;
      got = {pixel_x, pixel_y, glyph_out, plotted, last};
      pixels_seen++;
      if (!plotted) rejects_seen++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected pixel %h", got);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: pixel x/y/g/p/l exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                     want.px, want.py, want.glyph, want.plotted, want.last,
                     got.px, got.py, got.glyph, got.plotted, got.last);
        end
      end
    end
  end

  task automatic add_line(input int xs, input int ys, input int xe, input int ye,
                          input int g);
    line_t ln;
    ln.xs = 16'(xs); ln.ys = 16'(ys); ln.xe = 16'(xe); ln.ye = 16'(ye);
    ln.glyph = 8'(g);
    pending_lines.push_back(ln);
  endtask

  task automatic add_random_lines(input int count);
    int lim;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: add_line($urandom, $urandom, $urandom, $urandom, $urandom);
        1, 2: begin
          lim = 300;
          add_line($urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
                   $urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
                   $urandom);
        end
        default: add_line($urandom_range(90) - 15, $urandom_range(90) - 15,
                          $urandom_range(90) - 15, $urandom_range(90) - 15, $urandom);
      endcase
    end
  endtask

  // Waits until every queued line has gone and every pixel has come back.
  task automatic drain();
    wait (pending_lines.size() == 0 && !in_valid && expected_pixels.size() == 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_canvas(input logic [6:0] w, input logic [6:0] h);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_WIDTH; cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT; cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = w; height_reg = h;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 24; recv_idle_pct = 87;
    // Directed lines at the reset canvas size.
    add_line(0, 0, 63, 63, 8'h41);
    add_line(63, 0, 0, 63, 8'hFF);
    add_line(5, 5, 5, 5, 8'h00);
    add_line(0, 10, 63, 12, 8'h55);
    add_line(-32768, -32768, 32767, 32767, 8'hAA);
    add_line(32767, -32768, -32768, 32767, 8'h01);
    add_line(-10, -10, -5, 100, 8'h02);
    add_line(-100, 20, 200, 30, 8'h03);
    add_line(10, 10, 200, -50, 8'h04);
    add_line(30, -40, 20, 90, 8'h05);
    add_line(100, 100, 120, 130, 8'h06);
    add_line(-1, 0, -1, 63, 8'h07);
    add_line(20, 50, 10, 5, 8'h80);
    add_random_lines(25);
    drain();
    // Pause until the block is idle, then try the largest width and a height of one.
    hold_lines = 1'b1;
    drain();
    set_canvas(7'd127, 7'd1);
    hold_lines = 1'b0;
    add_line(-5, 0, 200, 0, 8'h11);
    add_line(3, -3, 3, 3, 8'h12);
    add_random_lines(20);
    drain();
    set_canvas(7'd0, 7'd40);
    add_line(0, 0, 10, 10, 8'h13);
    add_random_lines(6);
    drain();
    send_idle_pct = 87; recv_idle_pct = 24;
    set_canvas(7'd17, 7'd9);
    add_random_lines(50);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_canvas(7'd64, 7'd33);
    add_random_lines(45);
    drain();
    $display("Sent %0d lines over five canvas sizes; checked %0d pixels, %0d rejects.",
             lines_sent, pixels_seen, rejects_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
